// ===== rtl/overwriting_ring_fifo_window_macros.svh =====
// assertion macros shared by the ring fifo checker
`ifndef OVERWRITING_RING_FIFO_WINDOW_MACROS_SVH
`define OVERWRITING_RING_FIFO_WINDOW_MACROS_SVH

// same-cycle implication, held off during reset
`define OFW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define OFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ofw_pkg.sv =====
// types and constants of the overwriting ring fifo
package ofw_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int DATA_W_DEF = 16;
  localparam int CAP_W      = 7;
  localparam int CNT_W      = 7;
  localparam int WIN_W      = 7;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_WIN = 2'd2,
    CMD_CLR = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_DROP  = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ENQ_WR,
    S_WIN_RD,
    S_RD_WAIT,
    S_OUT
  } state_t;

endpackage

// ===== rtl/ofw_in_if.sv =====
// command channel of the ring fifo
interface ofw_in_if #(
  parameter int DATA_WIDTH = ofw_pkg::DATA_W_DEF
);
  logic                        valid;
  logic                        ready;
  logic [ofw_pkg::CMD_W-1:0]   cmd;
  logic [DATA_WIDTH-1:0]       data_in;
  logic [ofw_pkg::WIN_W-1:0]   window_count;

  modport source (output valid, output cmd, output data_in, output window_count,
                  input ready);
  modport sink (input valid, input cmd, input data_in, input window_count,
                output ready);
endinterface

// ===== rtl/ofw_out_if.sv =====
// result channel of the ring fifo
interface ofw_out_if #(
  parameter int DATA_WIDTH = ofw_pkg::DATA_W_DEF
);
  logic                        valid;
  logic                        ready;
  logic [DATA_WIDTH-1:0]       data_out;
  logic                        last;
  logic [ofw_pkg::STAT_W-1:0]  status;
  logic [ofw_pkg::CNT_W-1:0]   occupancy;

  modport source (output valid, output data_out, output last, output status,
                  output occupancy, input ready);
  modport sink (input valid, input data_out, input last, input status,
                input occupancy, output ready);
endinterface

// ===== rtl/ofw_ram.sv =====
// generic single-write, single-read ram with registered read data
module ofw_ram #(
  parameter int WIDTH = ofw_pkg::DATA_W_DEF,
  parameter int DEPTH = ofw_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/overwriting_ring_fifo_window.sv =====
// overwriting ring fifo with window read: top level
// one command at a time; a shared index incrementer with wrap compare does all advances
// enqueue steps: accept, update front and count, write, result (S_IDLE, S_EXEC, S_ENQ_WR, S_OUT)
// dequeue: accept, update, registered ram read, result; clear and dequeue from empty skip the read
// window of n words: one ram read per word, words leave in order
// synchronous active-low reset: capacity 64, fifo empty, front 1, per-entry valid bits read as zero
module overwriting_ring_fifo_window #(
  parameter int DEPTH      = ofw_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ofw_pkg::DATA_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ofw_in_if.sink                    in_ch,
  ofw_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [ofw_pkg::CAP_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [ofw_pkg::CAP_W-1:0] DEPTH_C = ofw_pkg::CAP_W'(DEPTH);

  ofw_pkg::state_t state_r, state_nxt;
  ofw_pkg::cmd_t   cmd_r, cmd_nxt;
  ofw_pkg::stat_t  out_stat_r, out_stat_nxt;

  logic [ofw_pkg::CAP_W-1:0] capacity_r, capacity_nxt;
  logic [IDX_W-1:0]          front_r, front_nxt;
  logic [IDX_W-1:0]          rear_r, rear_nxt;
  logic [ofw_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [DATA_WIDTH-1:0]     data_r, data_nxt;
  logic [ofw_pkg::WIN_W-1:0] want_r, want_nxt;
  logic [ofw_pkg::WIN_W-1:0] remain_r, remain_nxt;
  logic [IDX_W-1:0]          win_idx_r, win_idx_nxt;
  logic                      last_pend_r, last_pend_nxt;
  logic [DATA_WIDTH-1:0]     out_data_r, out_data_nxt;
  logic                      out_last_r, out_last_nxt;
  logic [DEPTH-1:0]          valid_r, valid_nxt;
  logic                      rd_valid_r;

  logic [ofw_pkg::CAP_W-1:0] cap_eff;
  logic [ofw_pkg::WIN_W-1:0] win_n;
  logic [IDX_W-1:0]          win_first;
  logic                      in_acc;
  logic                      out_acc;

  // shared index advance unit
  logic [IDX_W-1:0]          adv_in;
  logic [ofw_pkg::CAP_W-1:0] adv_sum;
  logic [IDX_W-1:0]          adv_out;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // a capacity of zero acts as one, above the depth as the depth
  assign cap_eff = (capacity_r == '0)    ? ofw_pkg::CAP_W'(1) :
                   (capacity_r > DEPTH_C) ? DEPTH_C : capacity_r;

  assign win_n     = (want_r > cap_eff) ? cap_eff : want_r;
  assign win_first = (ofw_pkg::CAP_W'(front_r) < cap_eff) ? front_r : '0;

  always_comb begin
    case (state_r)
      ofw_pkg::S_ENQ_WR: adv_in = rear_r;
      ofw_pkg::S_WIN_RD: adv_in = win_idx_r;
      default:           adv_in = front_r;
    endcase
  end

  assign adv_sum = ofw_pkg::CAP_W'(adv_in) + ofw_pkg::CAP_W'(1);
  assign adv_out = (adv_sum >= cap_eff) ? '0 : adv_sum[IDX_W-1:0];

  assign ram_we    = (state_r == ofw_pkg::S_ENQ_WR);
  assign ram_waddr = adv_out;
  assign ram_raddr = (state_r == ofw_pkg::S_WIN_RD) ? win_idx_r : front_r;

  ofw_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ofw_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = ofw_pkg::S_EXEC;
        end
      end
      ofw_pkg::S_EXEC: begin
        case (cmd_r)
          ofw_pkg::CMD_ENQ: state_nxt = ofw_pkg::S_ENQ_WR;
          ofw_pkg::CMD_DEQ: state_nxt = (count_r == '0) ? ofw_pkg::S_OUT : ofw_pkg::S_RD_WAIT;
          ofw_pkg::CMD_WIN: state_nxt = (win_n == '0) ? ofw_pkg::S_IDLE : ofw_pkg::S_WIN_RD;
          default:          state_nxt = ofw_pkg::S_OUT;
        endcase
      end
      ofw_pkg::S_ENQ_WR:  state_nxt = ofw_pkg::S_OUT;
      ofw_pkg::S_WIN_RD:  state_nxt = ofw_pkg::S_RD_WAIT;
      ofw_pkg::S_RD_WAIT: state_nxt = ofw_pkg::S_OUT;
      ofw_pkg::S_OUT: begin
        if (out_acc) begin
          if (cmd_r == ofw_pkg::CMD_WIN && !out_last_r) begin
            state_nxt = ofw_pkg::S_WIN_RD;
          end else begin
            state_nxt = ofw_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = ofw_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    capacity_nxt  = cfg_we ? cfg_data : capacity_r;
    cmd_nxt       = cmd_r;
    data_nxt      = data_r;
    want_nxt      = want_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    win_idx_nxt   = win_idx_r;
    last_pend_nxt = last_pend_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    valid_nxt     = valid_r;

    case (state_r)
      ofw_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = ofw_pkg::cmd_t'(in_ch.cmd);
          data_nxt = in_ch.data_in;
          want_nxt = in_ch.window_count;
        end
      end
      ofw_pkg::S_EXEC: begin
        out_data_nxt  = '0;
        out_last_nxt  = 1'b1;
        out_stat_nxt  = ofw_pkg::STAT_OK;
        last_pend_nxt = 1'b1;
        case (cmd_r)
          ofw_pkg::CMD_ENQ: begin
            // full: drop the oldest before the write
            if (count_r >= cap_eff) begin
              front_nxt    = adv_out;
              count_nxt    = cap_eff;
              out_stat_nxt = ofw_pkg::STAT_DROP;
            end else begin
              count_nxt = count_r + ofw_pkg::CNT_W'(1);
            end
          end
          ofw_pkg::CMD_DEQ: begin
            if (count_r == '0) begin
              out_stat_nxt = ofw_pkg::STAT_EMPTY;
            end else begin
              count_nxt = count_r - ofw_pkg::CNT_W'(1);
              front_nxt = adv_out;
            end
          end
          ofw_pkg::CMD_WIN: begin
            remain_nxt  = win_n;
            win_idx_nxt = win_first;
          end
          default: begin
            front_nxt = (cap_eff == ofw_pkg::CAP_W'(1)) ? '0 : IDX_W'(1);
            rear_nxt  = '0;
            count_nxt = '0;
          end
        endcase
      end
      ofw_pkg::S_ENQ_WR: begin
        rear_nxt           = adv_out;
        valid_nxt[adv_out] = 1'b1;
      end
      ofw_pkg::S_WIN_RD: begin
        win_idx_nxt   = adv_out;
        remain_nxt    = remain_r - ofw_pkg::WIN_W'(1);
        last_pend_nxt = (remain_r == ofw_pkg::WIN_W'(1));
      end
      ofw_pkg::S_RD_WAIT: begin
        // slots never written read as zero
        out_data_nxt = rd_valid_r ? ram_rdata : '0;
        out_last_nxt = last_pend_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ofw_pkg::S_IDLE;
      capacity_r <= ofw_pkg::CAP_RESET;
      front_r    <= IDX_W'(1);
      rear_r     <= '0;
      count_r    <= '0;
      valid_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      capacity_r <= capacity_nxt;
      front_r    <= front_nxt;
      rear_r     <= rear_nxt;
      count_r    <= count_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    data_r      <= data_nxt;
    want_r      <= want_nxt;
    remain_r    <= remain_nxt;
    win_idx_r   <= win_idx_nxt;
    last_pend_r <= last_pend_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_stat_r  <= out_stat_nxt;
    rd_valid_r  <= valid_r[ram_raddr];
  end

  assign in_ch.ready      = (state_r == ofw_pkg::S_IDLE);
  assign out_ch.valid     = (state_r == ofw_pkg::S_OUT);
  assign out_ch.data_out  = out_data_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.status    = out_stat_r;
  assign out_ch.occupancy = count_r;

endmodule

// ===== rtl/ofw_checker.sv =====
// port-level checks of the ring fifo, bound to the top level
`include "overwriting_ring_fifo_window_macros.svh"

module ofw_checker #(
  parameter int DEPTH      = ofw_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ofw_pkg::DATA_W_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [DATA_WIDTH-1:0]      out_data,
  input logic                       out_last,
  input logic [ofw_pkg::STAT_W-1:0] out_status,
  input logic [ofw_pkg::CNT_W-1:0]  out_occupancy
);

  localparam logic [ofw_pkg::CNT_W-1:0] OCC_MAX = ofw_pkg::CNT_W'(DEPTH);

  logic in_beat;
  logic out_pending;
  logic out_empty;
  logic out_drop;

  assign in_beat     = in_valid && in_ready;
  assign out_pending = out_valid && out_ready;
  assign out_empty   = out_valid && (out_status == ofw_pkg::STAT_EMPTY);
  assign out_drop    = out_valid && (out_status == ofw_pkg::STAT_DROP);

  // one command at a time: no new beat while a result is offered
  `OFW_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input ready with result pending")
  // an accepted command is worked on before anything else shows
  `OFW_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_beat, !in_ready && !out_valid, "not busy after beat")
  // dequeue from empty leaves an empty fifo and a zero word
  `OFW_ASSERT_NOW(a_empty_deq, clk, rst_n, out_empty, (out_data == '0) && out_last && (out_occupancy == '0), "bad empty dequeue result")
  // a drop happens only on a full fifo and gives a single zero result
  `OFW_ASSERT_NOW(a_drop, clk, rst_n, out_drop, (out_data == '0) && out_last && (out_occupancy != '0), "bad drop result")
  // the count never exceeds the store on a taken result beat
  `OFW_ASSERT_NOW(a_occ_max, clk, rst_n, out_pending, out_occupancy <= OCC_MAX, "occupancy above depth")

endmodule

bind overwriting_ring_fifo_window ofw_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_ofw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_data      (out_ch.data_out),
  .out_last      (out_ch.last),
  .out_status    (out_ch.status),
  .out_occupancy (out_ch.occupancy)
);

// ===== tb/sv/ofw_result_checker.sv =====
// result checker of the ring fifo: predicts each result beat from the commands and compares
module ofw_result_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  ofw_in_if                         cmd_ch,
  ofw_out_if                        res_ch,
  input  logic                      cfg_we,
  input  logic [ofw_pkg::CAP_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ofw_pkg::*;

  localparam int SLOTS = DEPTH_DEF;
  localparam int DW    = DATA_W_DEF;

  typedef struct {
    logic [DW-1:0]    data;
    logic             last;
    stat_t            status;
    logic [CNT_W-1:0] occupancy;
  } fifo_result_t;

  logic [DW-1:0]    store_mem [SLOTS];
  logic [5:0]       head_idx;
  logic [5:0]       tail_idx;
  logic [CNT_W-1:0] fill;
  logic [CAP_W-1:0] cap_reg;
  fifo_result_t     pending_results [$];

  // capacity as the block uses it: 0 acts as 1, anything above the depth as the depth
  function automatic logic [CAP_W-1:0] live_capacity();
    if (cap_reg == 0) return 7'd1;
    if (cap_reg > SLOTS) return 7'(SLOTS);
    return cap_reg;
  endfunction

  // an index at or past the last slot (capacity minus one) wraps to 0 on its next advance
  function automatic logic [5:0] step_index(logic [5:0] v);
    logic [6:0] n;
    n = {1'b0, v} + 7'd1;
    return (n >= live_capacity()) ? 6'd0 : n[5:0];
  endfunction

  function automatic void queue_result(logic [DW-1:0] data, logic last, stat_t st);
    fifo_result_t r;
    r.data      = data;
    r.last      = last;
    r.status    = st;
    r.occupancy = fill;
    pending_results.push_back(r);
  endfunction

  function automatic void model_command(cmd_t c, logic [DW-1:0] word,
                                        logic [WIN_W-1:0] want);
    logic [CAP_W-1:0] cap;
    logic [6:0]       n;
    logic [6:0]       first;
    logic [6:0]       idx;
    stat_t            st;
    cap = live_capacity();
    case (c)
      CMD_ENQ: begin
        st = STAT_OK;
        if (fill >= cap) begin
          // full: oldest entry goes first
          head_idx = step_index(head_idx);
          fill     = cap;
          st       = STAT_DROP;
        end else begin
          fill = fill + 7'd1;
        end
        tail_idx = step_index(tail_idx);
        store_mem[tail_idx] = word;
        queue_result('0, 1'b1, st);
      end
      CMD_DEQ: begin
        if (fill == 0) begin
          queue_result('0, 1'b1, STAT_EMPTY);
        end else begin
          word     = store_mem[head_idx];
          fill     = fill - 7'd1;
          head_idx = step_index(head_idx);
          queue_result(word, 1'b1, STAT_OK);
        end
      end
      CMD_WIN: begin
        n     = (want > cap) ? cap : want;
        first = ({1'b0, head_idx} < cap) ? {1'b0, head_idx} : 7'd0;
        for (int i = 0; i < n; i++) begin
          idx = first + 7'(i);
          if (idx >= cap) idx = idx - cap;
          queue_result(store_mem[idx[5:0]], (i + 1 == n), STAT_OK);
        end
      end
      default: begin
        head_idx = (cap == 1) ? 6'd0 : 6'd1;
        tail_idx = '0;
        fill     = '0;
        queue_result('0, 1'b1, STAT_OK);
      end
    endcase
  endfunction

  function automatic void check_field(string field, logic [DW-1:0] exp_v,
                                      logic [DW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", field, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) store_mem[i] = '0;
      cap_reg    = CAP_RESET;
      head_idx   = 6'd1;
      tail_idx   = '0;
      fill       = '0;
      mismatches = 0;
      pending_results.delete();
    end else begin
      // result beats come from earlier commands, so check them before taking a new one
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no command awaiting it");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("data_out", want.data, res_ch.data_out);
          check_field("last", 16'(want.last), 16'(res_ch.last));
          check_field("status", 16'(want.status), 16'(res_ch.status));
          check_field("occupancy", 16'(want.occupancy), 16'(res_ch.occupancy));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready)
        model_command(cmd_t'(cmd_ch.cmd), cmd_ch.data_in, cmd_ch.window_count);
      if (cfg_we) cap_reg = cfg_data;
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the ring fifo testbench: clock, reset, command stimulus and the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ofw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN       = 8;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 50;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  logic             sink_ready = 1'b0;
  bit               steady = 1'b0;
  int               fail_count;
  int               outstanding;
  int               stalled = 0;

  ofw_in_if  in_ch ();
  ofw_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  overwriting_ring_fifo_window dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  ofw_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_ch      (in_ch),
    .res_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mismatches  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    sink_ready <= steady || ($urandom_range(0, 99) >= 38);
  end

  // watchdog: cycles in a row with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled <= 0;
    end else if (stalled + 1 >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  task automatic issue(cmd_t c, logic [DATA_W_DEF-1:0] word, logic [WIN_W-1:0] count);
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= c;
    in_ch.data_in      <= word;
    in_ch.window_count <= count;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // idle the command side until every predicted beat is out, then let a zero window finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_command(int enq_pct);
    int pick;
    logic [WIN_W-1:0] count;
    pick  = $urandom_range(0, 99);
    count = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(1, 8));
    if (pick < enq_pct)
      issue(CMD_ENQ, 16'($urandom), count);
    else if (pick < enq_pct + (100 - enq_pct) * 45 / 100)
      issue(CMD_DEQ, 16'($urandom), count);
    else if (pick < enq_pct + (100 - enq_pct) * 85 / 100)
      issue(CMD_WIN, 16'($urandom), count);
    else
      issue(CMD_CLR, 16'($urandom), count);
  endtask

  initial begin
    logic [CAP_W-1:0] caps [PHASES];
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_ENQ;
    in_ch.data_in      <= '0;
    in_ch.window_count <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty fifo, edge words, saturating and zero windows, clear
    issue(CMD_WIN, 16'h0000, 7'd0);
    issue(CMD_DEQ, 16'hffff, 7'd1);
    issue(CMD_ENQ, 16'h0000, 7'd0);
    issue(CMD_ENQ, 16'hffff, 7'd127);
    issue(CMD_WIN, 16'h0000, 7'd127);
    issue(CMD_WIN, 16'h0000, 7'd1);
    issue(CMD_DEQ, 16'h0000, 7'd1);
    issue(CMD_DEQ, 16'h0000, 7'd1);
    issue(CMD_DEQ, 16'h0000, 7'd1);
    issue(CMD_ENQ, 16'ha5a5, 7'd0);
    issue(CMD_CLR, 16'h5a5a, 7'd0);
    issue(CMD_WIN, 16'h0000, 7'd65);
    // zero capacity behaves as one slot
    set_capacity(7'd0);
    issue(CMD_ENQ, 16'h1234, 7'd0);
    issue(CMD_ENQ, 16'h5678, 7'd0);
    issue(CMD_WIN, 16'h0000, 7'd2);
    issue(CMD_DEQ, 16'h0000, 7'd0);
    issue(CMD_CLR, 16'h0000, 7'd0);
    set_capacity(7'd3);
    issue(CMD_ENQ, 16'h0001, 7'd0);
    issue(CMD_ENQ, 16'h0002, 7'd0);
    issue(CMD_ENQ, 16'h0003, 7'd0);
    issue(CMD_ENQ, 16'h0004, 7'd0);
    issue(CMD_WIN, 16'h0000, 7'd3);
    issue(CMD_DEQ, 16'h0000, 7'd0);
    // capacity lowered beneath the live indices
    set_capacity(7'd2);
    issue(CMD_ENQ, 16'hbeef, 7'd0);
    issue(CMD_WIN, 16'h0000, 7'd64);

    caps = '{7'd64, 7'd127, 7'd1, 7'd5, 7'($urandom_range(1, 64)),
             7'd0, 7'd64, 7'd17, 7'd2, 7'($urandom_range(0, 127))};
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(caps[p]);
      steady = (p == 4 || p == 5);
      // lean on enqueue at full size so the overwrite path is reached there too
      for (int k = 0; k < PHASE_ITEMS; k++)
        random_command((caps[p] >= 64) ? 85 : 40);
    end
    steady = 1'b0;

    settle();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
